// ----- design/kvlv_pkg.sv -----
`default_nettype none

package kvlv_pkg;

   // Width of each limit register and of the register index.
   localparam int CFG_W = 10;
   localparam int CSR_INDEX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LINE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_KEY   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_VALUE = 2'd2;

   // Reset values of the limit registers.
   localparam logic [CFG_W-1:0] MAX_LINE_RESET  = 10'd256;
   localparam logic [CFG_W-1:0] MAX_KEY_RESET   = 10'd64;
   localparam logic [CFG_W-1:0] MAX_VALUE_RESET = 10'd192;

   // Default width of the per-line byte counters.
   localparam int COUNT_BITS_DEF = 11;

   // Field widths of the result word.
   localparam int VERDICT_W = 3;
   localparam int LINE_NUM_W = 32;

   // Verdict codes.
   localparam logic [VERDICT_W-1:0] VERDICT_PAIR_OK    = 3'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_BLANK      = 3'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_LINE_LONG  = 3'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_NO_EQUAL   = 3'd3;
   localparam logic [VERDICT_W-1:0] VERDICT_EMPTY_KEY  = 3'd4;
   localparam logic [VERDICT_W-1:0] VERDICT_KEY_LONG   = 3'd5;
   localparam logic [VERDICT_W-1:0] VERDICT_BAD_KEY    = 3'd6;
   localparam logic [VERDICT_W-1:0] VERDICT_VALUE_LONG = 3'd7;

   // Scan phases of a line.
   localparam logic [1:0] PH_LEAD    = 2'd0;
   localparam logic [1:0] PH_KEY     = 2'd1;
   localparam logic [1:0] PH_VALUE   = 2'd2;
   localparam logic [1:0] PH_COMMENT = 2'd3;

   // Character codes the scanner looks for.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // Line flags handed from the scanner to the verdict logic.
   typedef struct packed {
      logic [1:0] phase;
      logic       comment;
      logic       bad_key;
   } scan_flags_type;

   // Space means tab through carriage return, or a blank.
   function automatic logic is_space_byte(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // Key bytes are alphanumerics, underscore, dash and dot.
   function automatic logic is_key_byte(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDER) || (c == CH_DASH) ||
             (c == CH_DOT);
   endfunction

endpackage

`default_nettype wire

// ----- design/kvlv_scan.sv -----
`default_nettype none

module kvlv_scan #(
   parameter int COUNT_BITS = kvlv_pkg::COUNT_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire logic [7:0]            char_in,
   input  wire logic                  line_end,
   output kvlv_pkg::scan_flags_type   flags,
   output logic [COUNT_BITS-1:0]      raw_count,
   output logic [COUNT_BITS-1:0]      key_count,
   output logic [COUNT_BITS-1:0]      value_trim_count
);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   logic [1:0]            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] raw_ff, raw_in;
   logic [COUNT_BITS-1:0] key_ff, key_in;
   logic [COUNT_BITS-1:0] vraw_ff, vraw_in;
   logic [COUNT_BITS-1:0] vtrim_ff, vtrim_in;
   logic                  comment_ff, comment_in;
   logic                  bad_key_ff, bad_key_in;
   logic                  nul_ff, nul_in;
   logic [COUNT_BITS-1:0] raw_inc, key_inc, vraw_inc;
   logic                  space_byte, key_byte;

   // Saturating increments of the byte counters.
   assign raw_inc  = (raw_ff  == CNT_MAX) ? CNT_MAX : raw_ff  + 1'b1;
   assign key_inc  = (key_ff  == CNT_MAX) ? CNT_MAX : key_ff  + 1'b1;
   assign vraw_inc = (vraw_ff == CNT_MAX) ? CNT_MAX : vraw_ff + 1'b1;

   assign space_byte = kvlv_pkg::is_space_byte(char_in);
   assign key_byte   = kvlv_pkg::is_key_byte(char_in);

   // Next state of the line scan for one accepted word.
   always_comb begin
      phase_in   = phase_ff;
      raw_in     = raw_ff;
      key_in     = key_ff;
      vraw_in    = vraw_ff;
      vtrim_in   = vtrim_ff;
      comment_in = comment_ff;
      bad_key_in = bad_key_ff;
      nul_in     = nul_ff;
      if (take) begin
         if (line_end) begin
            phase_in   = kvlv_pkg::PH_LEAD;
            raw_in     = '0;
            key_in     = '0;
            vraw_in    = '0;
            vtrim_in   = '0;
            comment_in = 1'b0;
            bad_key_in = 1'b0;
            nul_in     = 1'b0;
         end else if (!nul_ff) begin
            if (char_in == kvlv_pkg::CH_NUL) begin
               // A NUL ends the line content; later bytes are dropped.
               nul_in = 1'b1;
            end else begin
               raw_in = raw_inc;
               unique case (phase_ff)
                  kvlv_pkg::PH_LEAD: begin
                     if (!space_byte) begin
                        if (char_in == kvlv_pkg::CH_HASH) begin
                           comment_in = 1'b1;
                           phase_in   = kvlv_pkg::PH_COMMENT;
                        end else if (char_in == kvlv_pkg::CH_EQUAL) begin
                           phase_in = kvlv_pkg::PH_VALUE;
                        end else begin
                           key_in   = key_inc;
                           phase_in = kvlv_pkg::PH_KEY;
                           if (!key_byte) bad_key_in = 1'b1;
                        end
                     end
                  end
                  kvlv_pkg::PH_KEY: begin
                     if (char_in == kvlv_pkg::CH_EQUAL) begin
                        phase_in = kvlv_pkg::PH_VALUE;
                     end else begin
                        key_in = key_inc;
                        if (!key_byte) bad_key_in = 1'b1;
                     end
                  end
                  kvlv_pkg::PH_VALUE: begin
                     // The trimmed length follows the last non-space byte.
                     vraw_in = vraw_inc;
                     if (!space_byte) vtrim_in = vraw_inc;
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= kvlv_pkg::PH_LEAD;
         raw_ff     <= '0;
         key_ff     <= '0;
         vraw_ff    <= '0;
         vtrim_ff   <= '0;
         comment_ff <= 1'b0;
         bad_key_ff <= 1'b0;
         nul_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         raw_ff     <= raw_in;
         key_ff     <= key_in;
         vraw_ff    <= vraw_in;
         vtrim_ff   <= vtrim_in;
         comment_ff <= comment_in;
         bad_key_ff <= bad_key_in;
         nul_ff     <= nul_in;
      end
   end

   assign flags.phase      = phase_ff;
   assign flags.comment    = comment_ff;
   assign flags.bad_key    = bad_key_ff;
   assign raw_count        = raw_ff;
   assign key_count        = key_ff;
   assign value_trim_count = vtrim_ff;

endmodule

`default_nettype wire

// ----- design/key_value_line_validator_core.sv -----
// A verdict word appears on rsp in the cycle after its end-of-line word is accepted.
// Throughput: one word per cycle unless stalled; each byte only updates the scan counters and flags.
// req_tready drops only while a finished verdict waits on rsp_tready.
// Reset is synchronous and active high: it clears the line scan, the line count,
// sets the running all-valid flag and loads the default length limits.
`default_nettype none

module key_value_line_validator_core #(
   parameter int COUNT_BITS = kvlv_pkg::COUNT_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Line bytes in.
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [7:0]                         req_tdata,   // [7:0] char_in
   input  wire logic                               req_tlast,   // line_end
   // Verdicts out.
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [2:0] verdict, [3] line_ok, [4] all_lines_ok, [36:5] line count, [39:37] zero
   output logic [39:0]                             rsp_tdata,
   // Limit registers.
   input  wire logic                               csr_we,
   input  wire logic [kvlv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [kvlv_pkg::CFG_W-1:0]         csr_wdata
);

   localparam int CMP_W = (COUNT_BITS > kvlv_pkg::CFG_W) ? COUNT_BITS : kvlv_pkg::CFG_W;
   localparam logic [kvlv_pkg::LINE_NUM_W-1:0] LINE_MAX = {kvlv_pkg::LINE_NUM_W{1'b1}};

   logic [kvlv_pkg::CFG_W-1:0]      max_line_ff, max_key_ff, max_value_ff;
   logic                            take, line_done;
   kvlv_pkg::scan_flags_type        flags;
   logic [COUNT_BITS-1:0]           raw_count, key_count, vtrim_count;
   logic [CMP_W-1:0]                raw_w, key_w, vtrim_w, max_line_w, max_key_w, max_value_w;
   logic [kvlv_pkg::VERDICT_W-1:0]  verdict_in;
   logic                            ok_in;
   logic                            all_ok_ff, all_ok_in;
   logic [kvlv_pkg::LINE_NUM_W-1:0] line_cnt_ff, line_cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [kvlv_pkg::VERDICT_W-1:0]  rsp_verdict_ff;
   logic                            rsp_ok_ff, rsp_all_ok_ff;
   logic [kvlv_pkg::LINE_NUM_W-1:0] rsp_line_ff;

   // Input side stalls only when a waiting verdict is not taken.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;
   assign line_done  = take && req_tlast;

   // Limit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_line_ff  <= kvlv_pkg::MAX_LINE_RESET;
         max_key_ff   <= kvlv_pkg::MAX_KEY_RESET;
         max_value_ff <= kvlv_pkg::MAX_VALUE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kvlv_pkg::CSR_MAX_LINE:  max_line_ff  <= csr_wdata;
            kvlv_pkg::CSR_MAX_KEY:   max_key_ff   <= csr_wdata;
            kvlv_pkg::CSR_MAX_VALUE: max_value_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   kvlv_scan #(
      .COUNT_BITS(COUNT_BITS)
   ) u_scan (
      .clock            (clock),
      .reset            (reset),
      .take             (take),
      .char_in          (req_tdata),
      .line_end         (req_tlast),
      .flags            (flags),
      .raw_count        (raw_count),
      .key_count        (key_count),
      .value_trim_count (vtrim_count)
   );

   // Bring counts and limits to a common width for the compares.
   assign raw_w       = CMP_W'(raw_count);
   assign key_w       = CMP_W'(key_count);
   assign vtrim_w     = CMP_W'(vtrim_count);
   assign max_line_w  = CMP_W'(max_line_ff);
   assign max_key_w   = CMP_W'(max_key_ff);
   assign max_value_w = CMP_W'(max_value_ff);

   // Verdict of the finished line, checks in priority order.
   always_comb begin
      if (raw_w > max_line_w) begin
         verdict_in = kvlv_pkg::VERDICT_LINE_LONG;
      end else if ((flags.phase == kvlv_pkg::PH_LEAD) || flags.comment) begin
         verdict_in = kvlv_pkg::VERDICT_BLANK;
      end else if (flags.phase != kvlv_pkg::PH_VALUE) begin
         verdict_in = kvlv_pkg::VERDICT_NO_EQUAL;
      end else if (key_count == '0) begin
         verdict_in = kvlv_pkg::VERDICT_EMPTY_KEY;
      end else if (key_w > max_key_w) begin
         verdict_in = kvlv_pkg::VERDICT_KEY_LONG;
      end else if (flags.bad_key) begin
         verdict_in = kvlv_pkg::VERDICT_BAD_KEY;
      end else if (vtrim_w > max_value_w) begin
         verdict_in = kvlv_pkg::VERDICT_VALUE_LONG;
      end else begin
         verdict_in = kvlv_pkg::VERDICT_PAIR_OK;
      end
   end

   assign ok_in       = (verdict_in == kvlv_pkg::VERDICT_PAIR_OK) ||
                        (verdict_in == kvlv_pkg::VERDICT_BLANK);
   assign all_ok_in   = all_ok_ff && ok_in;
   assign line_cnt_in = (line_cnt_ff == LINE_MAX) ? LINE_MAX : line_cnt_ff + 1'b1;

   // Running flag and line count across lines.
   always_ff @(posedge clock) begin
      if (reset) begin
         all_ok_ff   <= 1'b1;
         line_cnt_ff <= '0;
      end else if (line_done) begin
         all_ok_ff   <= all_ok_in;
         line_cnt_ff <= line_cnt_in;
      end
   end

   // Result register.
   assign rsp_valid_in = line_done ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (line_done) begin
         rsp_verdict_ff <= verdict_in;
         rsp_ok_ff      <= ok_in;
         rsp_all_ok_ff  <= all_ok_in;
         rsp_line_ff    <= line_cnt_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_line_ff, rsp_all_ok_ff, rsp_ok_ff, rsp_verdict_ff};

`ifndef SYNTHESIS
   // A finished line always shows its verdict in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      line_done |=> rsp_valid_ff)
      else $error("verdict missing after end of line");

   // A waiting verdict blocks the input side.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while verdict stalled");

   // A failing line clears the running flag in the same word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> !rsp_all_ok_ff)
      else $error("all-lines flag set after a failing line");

   // The line count steps by one per finished line until saturation.
   assert property (@(posedge clock) disable iff (reset)
      (line_done && (line_cnt_ff != LINE_MAX)) |=> (line_cnt_ff == $past(line_cnt_ff) + 1'b1))
      else $error("line count did not advance");
`endif

endmodule

`default_nettype wire
